// File: rtl/core/efr_pkg.sv
// shared types, constants and arithmetic helpers for the euler frame rotation
package efr_pkg;

  localparam int TRIG_FRAC_BITS = 16;
  localparam int CORDIC_STEPS   = 30;
  localparam int VEC_W          = 32;
  localparam int ANG_W          = 16;
  localparam int XY_W           = 34;
  localparam int Z_W            = 33;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int MAT_W          = TRIG_FRAC_BITS + 4;
  localparam int FMUL_W         = 2 * MAT_W;
  localparam int PROD_W         = MAT_W + VEC_W;
  localparam int SUM_W          = PROD_W + 2;
  localparam int CORDIC_LAT     = CORDIC_STEPS + 2;
  localparam int TRIG_SH        = 30 - TRIG_FRAC_BITS;

  localparam logic signed [XY_W-1:0]   CORDIC_GAIN = XY_W'(64'sd652032874);
  localparam logic signed [XY_W-1:0]   TRIG_RND    = XY_W'(64'sd1 <<< (TRIG_SH - 1));
  localparam logic signed [FMUL_W-1:0] FMUL_RND    = FMUL_W'(64'sd1 <<< (TRIG_FRAC_BITS - 1));
  localparam logic signed [SUM_W-1:0]  SUM_RND     = SUM_W'(64'sd1 <<< (TRIG_FRAC_BITS - 1));
  localparam logic signed [SUM_W-1:0]  OUT_MAX     = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0]  OUT_MIN     = SUM_W'(-64'sd2147483648);
  localparam logic signed [ANG_W-1:0]  ANG_MIN     = {1'b1, {(ANG_W-1){1'b0}}};
  localparam logic signed [ANG_W-1:0]  ANG_MAX     = {1'b0, {(ANG_W-1){1'b1}}};

  typedef struct packed {
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
  } vec_t;

  typedef struct packed {
    vec_t                    vec;
    logic signed [ANG_W-1:0] roll;
    logic signed [ANG_W-1:0] pitch;
    logic signed [ANG_W-1:0] yaw;
  } item_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] out_x;
    logic signed [VEC_W-1:0] out_y;
    logic signed [VEC_W-1:0] out_z;
    logic                    saturated;
  } result_t;

  // arctangent of 2^-i in 2^-32 turns
  function automatic logic signed [Z_W-1:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return Z_W'(v);
  endfunction

  // fixed-point product with round half up
  function automatic logic signed [MAT_W-1:0] fmul(input logic signed [MAT_W-1:0] a,
                                                   input logic signed [MAT_W-1:0] b);
    logic signed [FMUL_W-1:0] p;
    p = FMUL_W'(a * b) + FMUL_RND;
    return MAT_W'(p >>> TRIG_FRAC_BITS);
  endfunction

endpackage

// File: rtl/core/efr_front.sv
// front end: takes input beats, negates the angles when func is set, holds a two-entry queue
module efr_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic                              func,
  input  logic signed [efr_pkg::VEC_W-1:0]  vec_x,
  input  logic signed [efr_pkg::VEC_W-1:0]  vec_y,
  input  logic signed [efr_pkg::VEC_W-1:0]  vec_z,
  input  logic signed [efr_pkg::ANG_W-1:0]  roll_angle,
  input  logic signed [efr_pkg::ANG_W-1:0]  pitch_angle,
  input  logic signed [efr_pkg::ANG_W-1:0]  yaw_angle,
  output logic                              item_valid,
  output efr_pkg::item_t                    item,
  input  logic                              item_take
);

  efr_pkg::item_t q [2];
  efr_pkg::item_t in_item;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     cnt;
  logic           do_push;
  logic           do_pop;

  function automatic logic signed [efr_pkg::ANG_W-1:0] neg_angle(
      input logic signed [efr_pkg::ANG_W-1:0] a, input logic n);
    logic signed [efr_pkg::ANG_W-1:0] r;
    r = a;
    if (n) begin
      r = (a == efr_pkg::ANG_MIN) ? efr_pkg::ANG_MAX : -a;
    end
    return r;
  endfunction

  always_comb begin
    in_item.vec.vec_x = vec_x;
    in_item.vec.vec_y = vec_y;
    in_item.vec.vec_z = vec_z;
    in_item.roll      = neg_angle(roll_angle, func);
    in_item.pitch     = neg_angle(pitch_angle, func);
    in_item.yaw       = neg_angle(yaw_angle, func);
  end

  assign full       = (cnt == 2'd2);
  assign item_valid = (cnt != 2'd0);
  assign item       = q[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// File: rtl/core/efr_cordic.sv
// pipelined rotation-mode cordic giving sine and cosine of a binary angle
module efr_cordic (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [efr_pkg::ANG_W-1:0]   angle,
  output logic signed [efr_pkg::TRIG_W-1:0]  sin_q,
  output logic signed [efr_pkg::TRIG_W-1:0]  cos_q
);

  localparam int N = efr_pkg::CORDIC_STEPS;

  logic signed [efr_pkg::XY_W-1:0] x [N+1];
  logic signed [efr_pkg::XY_W-1:0] y [N+1];
  logic signed [efr_pkg::Z_W-1:0]  z [N+1];
  logic                            flip [N+1];

  logic                            in_flip;
  logic [efr_pkg::ANG_W-1:0]       shifted;
  logic [efr_pkg::ANG_W-1:0]       a_mod;
  logic signed [efr_pkg::XY_W-1:0] c_rnd;
  logic signed [efr_pkg::XY_W-1:0] s_rnd;
  logic signed [efr_pkg::TRIG_W-1:0] c_tr;
  logic signed [efr_pkg::TRIG_W-1:0] s_tr;

  // outside [-pi/2, pi/2): turn by pi, negate at the end
  assign shifted = angle + {2'b01, {(efr_pkg::ANG_W-2){1'b0}}};
  assign in_flip = shifted[efr_pkg::ANG_W-1];
  assign a_mod   = {angle[efr_pkg::ANG_W-1] ^ in_flip, angle[efr_pkg::ANG_W-2:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= efr_pkg::CORDIC_GAIN;
      y[0]    <= '0;
      z[0]    <= efr_pkg::Z_W'($signed({a_mod, 16'b0}));
      flip[0] <= in_flip;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][efr_pkg::Z_W-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - efr_pkg::atan_turn(5'(i));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + efr_pkg::atan_turn(5'(i));
        end
        flip[i+1] <= flip[i];
      end
    end
  end

  // q30 down to the trig fraction width
  assign c_rnd = (x[N] + efr_pkg::TRIG_RND) >>> efr_pkg::TRIG_SH;
  assign s_rnd = (y[N] + efr_pkg::TRIG_RND) >>> efr_pkg::TRIG_SH;
  assign c_tr  = efr_pkg::TRIG_W'(c_rnd);
  assign s_tr  = efr_pkg::TRIG_W'(s_rnd);

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= flip[N] ? -c_tr : c_tr;
      sin_q <= flip[N] ? -s_tr : s_tr;
    end
  end

endmodule

// File: rtl/core/efr_back.sv
// back end: trig pipelines, rotation matrix, matrix-vector product, saturation
module efr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             item_valid,
  input  efr_pkg::item_t   item,
  output logic             item_take,
  output logic             res_valid,
  output efr_pkg::result_t res
);

  localparam int L  = efr_pkg::CORDIC_LAT;
  localparam int MW = efr_pkg::MAT_W;

  logic signed [efr_pkg::TRIG_W-1:0] sr_t, cr_t, sp_t, cp_t, sy_t, cy_t;
  logic signed [MW-1:0] sr, cr, sp, cp, sy, cy;

  logic          vld [L];
  efr_pkg::vec_t vdl [L+2];

  // first multiply stage
  logic                 v1;
  logic signed [MW-1:0] srsp, crsp, cpcy, crsy, srsy, cpsy, crcy, srcy, srcp, crcp;
  logic signed [MW-1:0] sp1, sy1, cy1;
  // matrix stage
  logic                 v2;
  logic signed [MW-1:0] r [3][3];
  // product stage
  logic                 v3;
  logic signed [efr_pkg::PROD_W-1:0] p [3][3];
  // sum, round, clip
  logic signed [efr_pkg::SUM_W-1:0] acc [3];
  logic [2:0]                        clip;
  logic signed [efr_pkg::VEC_W-1:0]  o [3];

  assign item_take = en && item_valid;

  efr_cordic u_roll  (.clk(clk), .en(en), .angle(item.roll),  .sin_q(sr_t), .cos_q(cr_t));
  efr_cordic u_pitch (.clk(clk), .en(en), .angle(item.pitch), .sin_q(sp_t), .cos_q(cp_t));
  efr_cordic u_yaw   (.clk(clk), .en(en), .angle(item.yaw),   .sin_q(sy_t), .cos_q(cy_t));

  assign sr = MW'(sr_t);
  assign cr = MW'(cr_t);
  assign sp = MW'(sp_t);
  assign cp = MW'(cp_t);
  assign sy = MW'(sy_t);
  assign cy = MW'(cy_t);

  always_ff @(posedge clk) begin
    if (en) begin
      vdl[0] <= item.vec;
      for (int i = 1; i < L + 2; i++) begin
        vdl[i] <= vdl[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      srsp <= efr_pkg::fmul(sr, sp);
      crsp <= efr_pkg::fmul(cr, sp);
      cpcy <= efr_pkg::fmul(cp, cy);
      crsy <= efr_pkg::fmul(cr, sy);
      srsy <= efr_pkg::fmul(sr, sy);
      cpsy <= efr_pkg::fmul(cp, sy);
      crcy <= efr_pkg::fmul(cr, cy);
      srcy <= efr_pkg::fmul(sr, cy);
      srcp <= efr_pkg::fmul(sr, cp);
      crcp <= efr_pkg::fmul(cr, cp);
      sp1  <= sp;
      sy1  <= sy;
      cy1  <= cy;

      r[0][0] <= cpcy;
      r[0][1] <= -crsy + efr_pkg::fmul(srsp, cy1);
      r[0][2] <= srsy + efr_pkg::fmul(crsp, cy1);
      r[1][0] <= cpsy;
      r[1][1] <= crcy + efr_pkg::fmul(srsp, sy1);
      r[1][2] <= -srcy + efr_pkg::fmul(crsp, sy1);
      r[2][0] <= -sp1;
      r[2][1] <= srcp;
      r[2][2] <= crcp;

      for (int k = 0; k < 3; k++) begin
        p[k][0] <= efr_pkg::PROD_W'(r[k][0] * vdl[L+1].vec_x);
        p[k][1] <= efr_pkg::PROD_W'(r[k][1] * vdl[L+1].vec_y);
        p[k][2] <= efr_pkg::PROD_W'(r[k][2] * vdl[L+1].vec_z);
      end

      res.out_x     <= o[0];
      res.out_y     <= o[1];
      res.out_z     <= o[2];
      res.saturated <= |clip;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = (efr_pkg::SUM_W'(p[k][0]) + efr_pkg::SUM_W'(p[k][1])
               + efr_pkg::SUM_W'(p[k][2]) + efr_pkg::SUM_RND) >>> efr_pkg::TRIG_FRAC_BITS;
      if (acc[k] > efr_pkg::OUT_MAX) begin
        o[k]    = efr_pkg::VEC_W'(efr_pkg::OUT_MAX);
        clip[k] = 1'b1;
      end else if (acc[k] < efr_pkg::OUT_MIN) begin
        o[k]    = efr_pkg::VEC_W'(efr_pkg::OUT_MIN);
        clip[k] = 1'b1;
      end else begin
        o[k]    = efr_pkg::VEC_W'(acc[k]);
        clip[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < L; i++) begin
        vld[i] <= 1'b0;
      end
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= item_valid;
      for (int i = 1; i < L; i++) begin
        vld[i] <= vld[i-1];
      end
      v1        <= vld[L-1];
      v2        <= v1;
      v3        <= v2;
      res_valid <= v3;
    end
  end

endmodule

// File: rtl/core/efr_outq.sv
// two-entry result queue facing the consumer
module efr_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  efr_pkg::result_t wr_data,
  output logic             qfull,
  input  logic             pop,
  output logic             empty,
  output efr_pkg::result_t rd_data
);

  efr_pkg::result_t q [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       cnt;
  logic             do_pop;

  assign qfull   = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign rd_data = q[rd_ptr];
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wr_ptr] <= wr_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (wr)     wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(wr) - 2'(do_pop);
    end
  end

endmodule

// File: rtl/core/euler_frame_rotation.sv
// top level of the euler zyx frame rotation block
//
//  channel   direction  handshake              beat contents
//  input     in         push / full            func, vec_x/y/z, roll/pitch/yaw_angle
//  result    out        pop / empty            out_x/y/z, saturated
//
// one beat per cycle sustained while the result queue has room; after its
// accepting edge a beat passes 32 cordic stages (30 iterations plus angle
// prep and rounding, the first loaded from the head of the input queue), two
// multiply stages for the matrix, one product stage, one sum/clip stage and
// the write into the two-entry result queue, whose head shows on the ports
// synchronous active-high reset clears queue pointers, queue counts and stage valid bits only
// the back pipeline moves as one; it holds while the result queue is full,
// and the input queue keeps taking beats until it too fills
module euler_frame_rotation (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic                              func,
  input  logic signed [efr_pkg::VEC_W-1:0]  vec_x,
  input  logic signed [efr_pkg::VEC_W-1:0]  vec_y,
  input  logic signed [efr_pkg::VEC_W-1:0]  vec_z,
  input  logic signed [efr_pkg::ANG_W-1:0]  roll_angle,
  input  logic signed [efr_pkg::ANG_W-1:0]  pitch_angle,
  input  logic signed [efr_pkg::ANG_W-1:0]  yaw_angle,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [efr_pkg::VEC_W-1:0]  out_x,
  output logic signed [efr_pkg::VEC_W-1:0]  out_y,
  output logic signed [efr_pkg::VEC_W-1:0]  out_z,
  output logic                              saturated
);

  efr_pkg::item_t   item;
  logic             item_valid;
  logic             item_take;
  efr_pkg::result_t res;
  efr_pkg::result_t head;
  logic             res_valid;
  logic             oq_full;
  logic             en;

  // whole back pipeline advances whenever the result queue has room
  assign en = !oq_full;

  efr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .func       (func),
    .vec_x      (vec_x),
    .vec_y      (vec_y),
    .vec_z      (vec_z),
    .roll_angle (roll_angle),
    .pitch_angle(pitch_angle),
    .yaw_angle  (yaw_angle),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  efr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .item_valid(item_valid),
    .item      (item),
    .item_take (item_take),
    .res_valid (res_valid),
    .res       (res)
  );

  // last stage beat lands in the queue on the same advance
  efr_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .wr     (en && res_valid),
    .wr_data(res),
    .qfull  (oq_full),
    .pop    (pop),
    .empty  (empty),
    .rd_data(head)
  );

  assign out_x     = head.out_x;
  assign out_y     = head.out_y;
  assign out_z     = head.out_z;
  assign saturated = head.saturated;

endmodule
